// ===== hw/rtl/mlsu_pkg.sv =====
package mlsu_pkg;

   localparam int MEM_BYTES = 4096;
   localparam int LANES     = 4;
   localparam int ROWS      = MEM_BYTES / LANES;
   localparam int ROW_W     = $clog2(ROWS);
   localparam int QDEPTH    = 2;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);

   localparam logic [31:0] MEM_START_RESET = 32'h1001_0000;

   localparam logic [2:0] FUNC_LB = 3'd0;
   localparam logic [2:0] FUNC_LH = 3'd1;
   localparam logic [2:0] FUNC_LW = 3'd2;
   localparam logic [2:0] FUNC_SB = 3'd3;
   localparam logic [2:0] FUNC_SH = 3'd4;
   localparam logic [2:0] FUNC_SW = 3'd5;

   typedef enum logic [1:0] {
      SIZE_BYTE,
      SIZE_HALF,
      SIZE_WORD
   } size_type;

   typedef enum logic [0:0] {
      BK_CLEAR,
      BK_RUN
   } back_state_type;

   // one classified access, as queued between front and back
   typedef struct packed {
      logic                             is_load;
      logic                             is_store;
      logic                             fault;
      size_type                         size;
      logic [1:0]                       rot;
      logic [LANES-1:0]                 byte_en;
      logic [LANES-1:0][ROW_W-1:0]      row;
      logic [LANES-1:0][7:0]            wdata;
      logic [4:0]                       dest_reg;
   } entry_type;

   function automatic logic [2:0] size_bytes(input size_type size);
      logic [2:0] n;
      unique case (size)
         SIZE_BYTE: n = 3'd1;
         SIZE_HALF: n = 3'd2;
         SIZE_WORD: n = 3'd4;
         default:   n = 3'd1;
      endcase
      return n;
   endfunction

endpackage

// ===== hw/rtl/mlsu_front.sv =====
module mlsu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_func,
   input  logic [31:0]         req_instruction,
   input  logic [31:0]         req_base_value,
   input  logic [31:0]         req_store_value,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data,
   input  logic                clear_busy,
   input  logic                q_full,
   output logic                q_push,
   output mlsu_pkg::entry_type q_entry
);

   logic        valid_ff, valid_in;
   logic [31:0] addr_ff, sval_ff, mem_start_ff;
   logic [2:0]  func_ff;
   logic [4:0]  target_ff;
   logic        accept;

   logic                 is_load, is_store, valid_op, misalign, bad;
   mlsu_pkg::size_type   size;
   logic [2:0]           nbytes;
   logic [31:0]          moff;
   logic [1:0]           rot, lane_off;

   assign req_stall = clear_busy || (valid_ff && q_full);
   assign accept    = req_valid && !req_stall;
   assign q_push    = valid_ff && !q_full;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         mem_start_ff <= mlsu_pkg::MEM_START_RESET;
      end else begin
         valid_ff <= valid_in;
         if (csr_wr_en) begin
            mem_start_ff <= csr_wr_data;
         end
      end
   end

   // effective address is formed here, range check in the next cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff   <= req_base_value + {{16{req_instruction[15]}}, req_instruction[15:0]};
         func_ff   <= req_func;
         target_ff <= req_instruction[20:16];
         sval_ff   <= req_store_value;
      end
   end

   always_comb begin
      is_load  = 1'b0;
      is_store = 1'b0;
      size     = mlsu_pkg::SIZE_BYTE;
      unique case (func_ff)
         mlsu_pkg::FUNC_LB: begin is_load  = 1'b1; size = mlsu_pkg::SIZE_BYTE; end
         mlsu_pkg::FUNC_LH: begin is_load  = 1'b1; size = mlsu_pkg::SIZE_HALF; end
         mlsu_pkg::FUNC_LW: begin is_load  = 1'b1; size = mlsu_pkg::SIZE_WORD; end
         mlsu_pkg::FUNC_SB: begin is_store = 1'b1; size = mlsu_pkg::SIZE_BYTE; end
         mlsu_pkg::FUNC_SH: begin is_store = 1'b1; size = mlsu_pkg::SIZE_HALF; end
         mlsu_pkg::FUNC_SW: begin is_store = 1'b1; size = mlsu_pkg::SIZE_WORD; end
         default: begin end
      endcase
      valid_op = is_load || is_store;
      nbytes   = mlsu_pkg::size_bytes(size);
      moff     = addr_ff - mem_start_ff;
      unique case (size)
         mlsu_pkg::SIZE_HALF: misalign = addr_ff[0];
         mlsu_pkg::SIZE_WORD: misalign = |addr_ff[1:0];
         default:             misalign = 1'b0;
      endcase
      bad = (moff > (32'(mlsu_pkg::MEM_BYTES) - {29'd0, nbytes})) || misalign;
      rot = moff[1:0];

      q_entry.is_load  = is_load;
      q_entry.is_store = is_store;
      q_entry.fault    = valid_op && bad;
      q_entry.size     = size;
      q_entry.rot      = rot;
      q_entry.dest_reg = is_load ? target_ff : 5'd0;
      // an unaligned window start spreads the access over two rows
      for (int l = 0; l < mlsu_pkg::LANES; l++) begin
         lane_off           = 2'(l) - rot;
         q_entry.byte_en[l] = valid_op && ({1'b0, lane_off} < nbytes);
         q_entry.row[l]     = moff[mlsu_pkg::ROW_W+1:2]
                              + mlsu_pkg::ROW_W'(2'(l) < rot);
         q_entry.wdata[l]   = sval_ff[8*lane_off +: 8];
      end
   end

endmodule

// ===== hw/rtl/mlsu_queue.sv =====
module mlsu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mlsu_pkg::entry_type push_entry,
   input  logic                pop,
   output mlsu_pkg::entry_type head,
   output logic                full,
   output logic                empty
);

   mlsu_pkg::entry_type                entries_ff [mlsu_pkg::QDEPTH];
   logic [mlsu_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [mlsu_pkg::QCNT_W-1:0]        count_ff, count_in;

   assign full  = (count_ff == mlsu_pkg::QCNT_W'(mlsu_pkg::QDEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mlsu_pkg::QPTR_W'(mlsu_pkg::QDEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mlsu_pkg::QPTR_W'(mlsu_pkg::QDEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hw/rtl/mlsu_back.sv =====
module mlsu_back (
   input  logic                clock,
   input  logic                reset,
   input  mlsu_pkg::entry_type head,
   input  logic                q_empty,
   output logic                q_pop,
   output logic                clear_busy,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_load_value,
   output logic [4:0]          rsp_dest_reg,
   output logic                rsp_reg_write,
   output logic                rsp_fault
);

   mlsu_pkg::back_state_type       state_ff, state_in;
   logic [mlsu_pkg::ROW_W-1:0]     clear_row_ff, clear_row_in;

   logic               acc_valid_ff, acc_valid_in, rsp_valid_ff, rsp_valid_in;
   logic               acc_move;
   logic               acc_is_load_ff, acc_fault_ff;
   mlsu_pkg::size_type acc_size_ff;
   logic [1:0]         acc_rot_ff;
   logic [4:0]         acc_dest_ff;

   wire  [mlsu_pkg::LANES-1:0][7:0] rdata;
   logic [mlsu_pkg::LANES-1:0][7:0] bytes;
   logic [31:0]                     value;

   logic [31:0] load_value_ff;
   logic [4:0]  dest_reg_ff;
   logic        reg_write_ff, fault_ff;

   // clearing sweep after reset, one row of every lane per cycle
   always_comb begin
      state_in     = state_ff;
      clear_row_in = clear_row_ff;
      clear_busy   = 1'b0;
      unique case (state_ff)
         mlsu_pkg::BK_CLEAR: begin
            clear_busy   = 1'b1;
            clear_row_in = clear_row_ff + 1'b1;
            if (clear_row_ff == mlsu_pkg::ROW_W'(mlsu_pkg::ROWS - 1)) begin
               state_in = mlsu_pkg::BK_RUN;
            end
         end
         mlsu_pkg::BK_RUN: begin
         end
         default: begin
            state_in = mlsu_pkg::BK_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlsu_pkg::BK_CLEAR;
         clear_row_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clear_row_ff <= clear_row_in;
      end
   end

   assign acc_move     = acc_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign q_pop        = !q_empty && !clear_busy && (!acc_valid_ff || acc_move);
   assign acc_valid_in = q_pop || (acc_valid_ff && !acc_move);
   assign rsp_valid_in = acc_move || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_valid_ff <= acc_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         acc_is_load_ff <= head.is_load;
         acc_fault_ff   <= head.fault;
         acc_size_ff    <= head.size;
         acc_rot_ff     <= head.rot;
         acc_dest_ff    <= head.dest_reg;
      end
   end

   // four byte lanes; read data holds until the next issue
   for (genvar l = 0; l < mlsu_pkg::LANES; l++) begin : g_lane
      logic [7:0]                 mem [mlsu_pkg::ROWS];
      logic [mlsu_pkg::ROW_W-1:0] lane_addr;
      logic                       lane_we;
      logic [7:0]                 lane_wdata;
      logic [7:0]                 rdata_ff;

      assign lane_addr  = clear_busy ? clear_row_ff : head.row[l];
      assign lane_we    = clear_busy
                          || (q_pop && head.is_store && !head.fault && head.byte_en[l]);
      assign lane_wdata = clear_busy ? 8'd0 : head.wdata[l];
      assign rdata[l]   = rdata_ff;

      always_ff @(posedge clock) begin
         if (lane_we) begin
            mem[lane_addr] <= lane_wdata;
         end
         if (q_pop) begin
            rdata_ff <= mem[lane_addr];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < mlsu_pkg::LANES; i++) begin
         bytes[i] = rdata[2'(i) + acc_rot_ff];
      end
      unique case (acc_size_ff)
         mlsu_pkg::SIZE_HALF: value = {{16{bytes[1][7]}}, bytes[1], bytes[0]};
         mlsu_pkg::SIZE_WORD: value = {bytes[3], bytes[2], bytes[1], bytes[0]};
         default:             value = {{24{bytes[0][7]}}, bytes[0]};
      endcase
   end

   always_ff @(posedge clock) begin
      if (acc_move) begin
         load_value_ff <= (acc_is_load_ff && !acc_fault_ff) ? value : 32'd0;
         dest_reg_ff   <= acc_dest_ff;
         reg_write_ff  <= acc_is_load_ff && !acc_fault_ff && (acc_dest_ff != 5'd0);
         fault_ff      <= acc_fault_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_load_value = load_value_ff;
   assign rsp_dest_reg   = dest_reg_ff;
   assign rsp_reg_write  = reg_write_ff;
   assign rsp_fault      = fault_ff;

endmodule

// ===== hw/rtl/mips_load_store_unit.sv =====
// Path from req transfer to rsp_valid: the address add is taken at the transfer,
// then range check and queue push, the queue entry register, memory access, result register.
// Throughput: one load or store per cycle unless req_stall or rsp_stall holds the
// flow; the byte-lane data memory has one port and each item uses it once.
// Reset: synchronous, active high; afterwards the data memory is swept to zero,
// MEM_BYTES/4 rows (1024 at 4096 bytes), with req_stall held high meanwhile.
module mips_load_store_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_instruction,
   input  logic [31:0] req_base_value,
   input  logic [31:0] req_store_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_load_value,
   output logic [4:0]  rsp_dest_reg,
   output logic        rsp_reg_write,
   output logic        rsp_fault,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   mlsu_pkg::entry_type push_entry, head;
   logic                q_push, q_pop, q_full, q_empty, clear_busy;

   mlsu_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_instruction (req_instruction),
      .req_base_value  (req_base_value),
      .req_store_value (req_store_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .clear_busy      (clear_busy),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_entry         (push_entry)
   );

   mlsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .full       (q_full),
      .empty      (q_empty)
   );

   mlsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .clear_busy     (clear_busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_load_value (rsp_load_value),
      .rsp_dest_reg   (rsp_dest_reg),
      .rsp_reg_write  (rsp_reg_write),
      .rsp_fault      (rsp_fault)
   );

endmodule

// ===== hw/rtl/mlsu_checker.sv =====
module mlsu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_load_value,
   input logic [4:0]  rsp_dest_reg,
   input logic        rsp_reg_write,
   input logic        rsp_fault
);

   // memory sweep starts right out of reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> (req_stall && !rsp_valid))
      else $error("input not held off after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_load_value)
         && $stable(rsp_dest_reg) && $stable(rsp_reg_write) && $stable(rsp_fault)))
      else $error("stalled response changed");

   a_write_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reg_write) |-> (rsp_dest_reg != 5'd0 && !rsp_fault))
      else $error("register write to r0 or on fault");

   a_fault_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fault) |-> (rsp_load_value == 32'd0 && !rsp_reg_write))
      else $error("faulting access returned data");

endmodule

bind mips_load_store_unit mlsu_checker u_mlsu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_load_value (rsp_load_value),
   .rsp_dest_reg   (rsp_dest_reg),
   .rsp_reg_write  (rsp_reg_write),
   .rsp_fault      (rsp_fault)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] instr;
      logic [31:0] base;
      logic [31:0] sval;
   } lsu_op_type;

   typedef struct packed {
      logic [31:0] load_value;
      logic [4:0]  dest_reg;
      logic        reg_write;
      logic        fault;
   } lsu_rsp_type;

   localparam int OPS_PER_SETTING = 67;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_func = '0;
   logic [31:0] req_instruction = '0;
   logic [31:0] req_base_value = '0;
   logic [31:0] req_store_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_load_value;
   logic [4:0]  rsp_dest_reg;
   logic        rsp_reg_write;
   logic        rsp_fault;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   // predictor state
   logic [31:0] cfg_mem_start = mlsu_pkg::MEM_START_RESET;
   bit   [7:0]  shadow_mem [0:mlsu_pkg::MEM_BYTES-1];

   lsu_op_type  pending_ops [$];
   lsu_rsp_type pending_results [$];
   lsu_op_type  cur_op;
   lsu_rsp_type got_rsp;
   lsu_rsp_type want_rsp;

   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   logic        hold_go = 1'b0;
   int          hold_left = 0;
   int          err_count = 0;
   logic [31:0] start_list [6];

   mips_load_store_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_instruction (req_instruction),
      .req_base_value  (req_base_value),
      .req_store_value (req_store_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_load_value  (rsp_load_value),
      .rsp_dest_reg    (rsp_dest_reg),
      .rsp_reg_write   (rsp_reg_write),
      .rsp_fault       (rsp_fault),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #6 clock = ~clock;

   // executes one access against the shadow memory, returns the expected result
   function automatic lsu_rsp_type execute_access(lsu_op_type op);
      lsu_rsp_type r;
      logic [31:0] offs;
      logic [31:0] addr;
      logic [31:0] moff;
      logic [31:0] val;
      logic [31:0] lim;
      int unsigned nbytes;
      logic        is_load;
      r = '0;
      if (op.func > mlsu_pkg::FUNC_SW) return r;
      offs = {{16{op.instr[15]}}, op.instr[15:0]};
      addr = op.base + offs;
      is_load = (op.func <= mlsu_pkg::FUNC_LW);
      case (op.func)
         mlsu_pkg::FUNC_LB, mlsu_pkg::FUNC_SB: nbytes = 1;
         mlsu_pkg::FUNC_LH, mlsu_pkg::FUNC_SH: nbytes = 2;
         default:                              nbytes = 4;
      endcase
      moff = addr - cfg_mem_start;
      lim = 32'(mlsu_pkg::MEM_BYTES) - 32'(nbytes);
      if (is_load) r.dest_reg = op.instr[20:16];
      if (moff > lim || (addr & 32'(nbytes - 1)) != 0) begin
         r.fault = 1'b1;
      end else if (is_load) begin
         val = '0;
         for (int i = 0; i < nbytes; i++) val[8*i +: 8] = shadow_mem[moff + i];
         if (nbytes == 1 && val[7]) val[31:8] = '1;
         if (nbytes == 2 && val[15]) val[31:16] = '1;
         r.load_value = val;
         r.reg_write = (r.dest_reg != 5'd0);
      end else begin
         for (int i = 0; i < nbytes; i++) shadow_mem[moff + i] = op.sval[8*i +: 8];
      end
      return r;
   endfunction

   // builds an access that lands at byte moff of the memory window
   function automatic lsu_op_type place_op(logic [2:0] func, logic [31:0] moff,
                                           logic [4:0] target, logic [31:0] sval,
                                           logic [15:0] offset);
      lsu_op_type  op;
      logic [31:0] hi;
      hi = $urandom();
      op.func  = func;
      op.instr = {hi[31:26], hi[25:21], target, offset};
      op.base  = cfg_mem_start + moff - {{16{offset[15]}}, offset};
      op.sval  = sval;
      return op;
   endfunction

   function automatic lsu_op_type gen_op();
      logic [2:0]  func;
      int unsigned nbytes;
      int unsigned kind;
      logic [31:0] addr;
      logic [4:0]  target;
      lsu_op_type  op;
      func = ($urandom_range(0, 99) < 4) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      case (func)
         mlsu_pkg::FUNC_LB, mlsu_pkg::FUNC_SB: nbytes = 1;
         mlsu_pkg::FUNC_LH, mlsu_pkg::FUNC_SH: nbytes = 2;
         default:                              nbytes = 4;
      endcase
      kind = $urandom_range(0, 99);
      target = ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom());
      // mostly a small hot window so loads see earlier stores
      if (kind < 70) begin
         addr = cfg_mem_start + $urandom_range(0, 127);
      end else if (kind < 82) begin
         addr = cfg_mem_start + $urandom_range(0, mlsu_pkg::MEM_BYTES - 1);
      end else if (kind < 90) begin
         addr = cfg_mem_start + mlsu_pkg::MEM_BYTES - nbytes + $urandom_range(0, 64);
      end else begin
         addr = cfg_mem_start - $urandom_range(1, 64);
      end
      if (kind < 82 && $urandom_range(0, 9) != 0) addr = addr & ~32'(nbytes - 1);
      op = place_op(func, addr - cfg_mem_start, target, $urandom(), 16'($urandom()));
      if (kind >= 96) begin
         op.base  = $urandom();
         op.instr = $urandom();
      end
      return op;
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_ops.size() != 0 || req_valid || pending_results.size() != 0);
   endtask

   task automatic write_mem_start(logic [31:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cfg_mem_start = value;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_results.push_back(execute_access(cur_op));
         end
         if (!req_valid || !req_stall) begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_op = pending_ops.pop_front();
               req_valid       <= 1'b1;
               req_func        <= cur_op.func;
               req_instruction <= cur_op.instr;
               req_base_value  <= cur_op.base;
               req_store_value <= cur_op.sval;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_go) begin
         hold_left <= 200;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_rsp = '{rsp_load_value, rsp_dest_reg, rsp_reg_write, rsp_fault};
            if (pending_results.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("unexpected transfer: load_value=%h dest_reg=%0d reg_write=%b fault=%b",
                           got_rsp.load_value, got_rsp.dest_reg, got_rsp.reg_write,
                           got_rsp.fault);
            end else begin
               want_rsp = pending_results.pop_front();
               if (got_rsp !== want_rsp) begin
                  err_count++;
                  if (err_count <= 10)
                     $display({"mismatch: exp load_value=%h dest_reg=%0d reg_write=%b fault=%b",
                               " got load_value=%h dest_reg=%0d reg_write=%b fault=%b"},
                              want_rsp.load_value, want_rsp.dest_reg, want_rsp.reg_write,
                              want_rsp.fault, got_rsp.load_value, got_rsp.dest_reg,
                              got_rsp.reg_write, got_rsp.fault);
               end
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   initial begin
      #2_400_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      start_list[0] = mlsu_pkg::MEM_START_RESET;
      start_list[1] = 32'h0000_0000;
      start_list[2] = 32'hFFFF_F000;
      start_list[3] = 32'hFFFF_FFFF;   // window wraps through zero, odd start
      start_list[4] = $urandom() & ~32'h3;
      start_list[5] = $urandom();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_mem_start(mlsu_pkg::MEM_START_RESET);
      send_idle_pct = 21;
      recv_idle_pct = 75;
      @(negedge clock);
      // sign and byte order
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_SW, 0, 5'd9, 32'h80FF_7F01, 16'h0000));
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_LW, 0, 5'd5, 32'hFFFF_FFFF, 16'h0004));
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_LB, 0, 5'd31, 32'h0, 16'hFFFF));
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_LB, 1, 5'd1, 32'h0, 16'h0001));
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_LB, 2, 5'd2, 32'h0, 16'h7FFF));
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_LH, 2, 5'd3, 32'h0, 16'h8000));
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_LH, 0, 5'd4, 32'h0, 16'h0000));
      // load to register zero
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_LW, 0, 5'd0, 32'h0, 16'h0010));
      // top of the window
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_SB, mlsu_pkg::MEM_BYTES - 1, 5'd7,
                                     32'h1234_56AB, 16'h0000));
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_LB, mlsu_pkg::MEM_BYTES - 1, 5'd8,
                                     32'h0, 16'hFFF0));
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_SH, mlsu_pkg::MEM_BYTES - 2, 5'd7,
                                     32'hFFFF_8001, 16'h0002));
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_LH, mlsu_pkg::MEM_BYTES - 2, 5'd10,
                                     32'h0, 16'h0000));
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_SW, mlsu_pkg::MEM_BYTES - 4, 5'd7,
                                     32'hFFFF_FFFF, 16'h8000));
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_LW, mlsu_pkg::MEM_BYTES - 4, 5'd11,
                                     32'h0, 16'h7FFF));
      // faults: out of range and misaligned
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_LW, mlsu_pkg::MEM_BYTES, 5'd12,
                                     32'h0, 16'h0000));
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_LH, mlsu_pkg::MEM_BYTES - 1, 5'd13,
                                     32'h0, 16'h0000));
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_LW, 2, 5'd14, 32'h0, 16'h0000));
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_SH, 1, 5'd15, 32'hDEAD_BEEF, 16'h0000));
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_SW, 32'hFFFF_FFFC, 5'd16,
                                     32'hDEAD_BEEF, 16'h0000));
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_LB, 32'hFFFF_FFFF, 5'd17,
                                     32'h0, 16'h0000));
      pending_ops.push_back(place_op(mlsu_pkg::FUNC_LW, 0, 5'd18, 32'h0, 16'h0000));
      // unused func codes
      pending_ops.push_back(place_op(3'd6, 0, 5'd19, 32'hFFFF_FFFF, 16'h0000));
      pending_ops.push_back(place_op(3'd7, 4, 5'd20, 32'hFFFF_FFFF, 16'h0000));
      wait_drained();

      for (int k = 0; k < 6; k++) begin
         repeat (4) @(posedge clock);
         write_mem_start(start_list[k]);
         @(negedge clock);
         if (k < 2) begin
            send_idle_pct = 21;
            recv_idle_pct = 75;
         end else if (k < 4) begin
            send_idle_pct = 75;
            recv_idle_pct = 21;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < OPS_PER_SETTING; n++) pending_ops.push_back(gen_op());
         if (k == 5) begin
            // receiver holds off while the sender keeps offering
            @(posedge clock);
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      err_count += pending_results.size();
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/mlsu_pkg.sv
hw/rtl/mlsu_front.sv
hw/rtl/mlsu_queue.sv
hw/rtl/mlsu_back.sv
hw/rtl/mips_load_store_unit.sv
hw/rtl/mlsu_checker.sv
bench/tb.sv
